// ----- rtl/core/srsw_pkg.sv -----
`timescale 1ns / 1ps

package srsw_pkg;

    // Sizes of the window ring and of frame numbers.
    localparam int WINDOW_MAX   = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int FRAME_BITS   = 16;
    localparam int SLOT_BITS    = $clog2(WINDOW_MAX);
    localparam int BASE_BITS    = FRAME_BITS + 1;
    localparam int WALK_BITS    = FRAME_BITS + 2;
    localparam int WIN_BITS     = 5;
    localparam int CNT_BITS     = 32;

    localparam int WIN_LIMIT = (WINDOW_MAX < RESULT_LIMIT) ? WINDOW_MAX : RESULT_LIMIT;

    // Slot states.
    localparam logic [1:0] SLOT_IDLE  = 2'd0;
    localparam logic [1:0] SLOT_SENT  = 2'd1;
    localparam logic [1:0] SLOT_ACKED = 2'd2;

    // Result kinds.
    localparam logic [2:0] EV_SENT     = 3'd0;
    localparam logic [2:0] EV_ACCEPTED = 3'd1;
    localparam logic [2:0] EV_LOST     = 3'd2;
    localparam logic [2:0] EV_IGNORED  = 3'd3;
    localparam logic [2:0] EV_NONE     = 3'd4;

    // Input command codes.
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_ACK  = 1'b1;

    // Slot read address selection.
    localparam logic [1:0] RD_WALK = 2'd0;
    localparam logic [1:0] RD_ACK  = 2'd1;
    localparam logic [1:0] RD_BASE = 2'd2;

    // Configuration register indexes.
    localparam logic REG_WIN_LEN     = 1'b0;
    localparam logic REG_FRAME_COUNT = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [FRAME_BITS-1:0] ack_frame;
        logic                  ack_ok;
    } in_t;

    typedef struct packed {
        logic [2:0]            event_kind;
        logic [15:0]           frame_number;
        logic [16:0]           window_base;
        logic                  all_done;
        logic [CNT_BITS-1:0]   transmissions;
        logic                  last;
    } out_t;

    typedef struct packed {
        logic       load;
        logic [1:0] rd_sel;
        logic       walk_adv;
        logic       walk_hit;
        logic       flush;
        logic       ack_set_acked;
        logic       ack_clear;
        logic       slide_adv;
        logic       set_kind;
        logic [2:0] kind;
        logic       ack_emit;
    } dp_cmd_t;

    typedef struct packed {
        logic is_ack;
        logic walk_end;
        logic slot_idle;
        logic ack_bad;
        logic ack_good;
        logic slide_more;
        logic out_free;
        logic pend_valid;
    } dp_status_t;

endpackage

// ----- rtl/core/srsw_datapath.sv -----
`timescale 1ns / 1ps

module srsw_datapath import srsw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [WIN_BITS-1:0]   win_eff,
    input  logic [FRAME_BITS-1:0] total_eff,
    input  in_t                   in_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data
);

    logic [1:0]            slot_reg [WINDOW_MAX];
    logic [BASE_BITS-1:0]  base_reg;
    logic [CNT_BITS-1:0]   tx_reg;
    logic [WALK_BITS-1:0]  cur_reg;
    logic [WIN_BITS-1:0]   cnt_reg;
    logic                  is_ack_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic                  ok_reg;
    logic [2:0]            kind_reg;
    logic                  pend_valid_reg;
    logic [15:0]           pend_frame_reg;
    logic [CNT_BITS-1:0]   pend_tx_reg;
    logic                  out_valid_reg;
    out_t                  out_reg;

    logic [SLOT_BITS-1:0]  rd_addr;
    logic [1:0]            slot_rd;
    logic [CNT_BITS-1:0]   tx_inc;
    logic [WALK_BITS-1:0]  win_end;
    logic                  done_now;
    logic                  out_free;

    always_comb begin
        case (cmd.rd_sel)
            RD_WALK: rd_addr = cur_reg[SLOT_BITS-1:0];
            RD_ACK:  rd_addr = frame_reg[SLOT_BITS-1:0];
            RD_BASE: rd_addr = base_reg[SLOT_BITS-1:0];
            default: rd_addr = cur_reg[SLOT_BITS-1:0];
        endcase
    end

    assign slot_rd  = slot_reg[rd_addr];
    assign tx_inc   = (tx_reg == {CNT_BITS{1'b1}}) ? tx_reg : tx_reg + 1'b1;
    assign win_end  = {1'b0, base_reg} + {{(WALK_BITS-WIN_BITS){1'b0}}, win_eff};
    assign done_now = base_reg > {1'b0, total_eff};
    assign out_free = !out_valid_reg || out_ready;

    always_comb begin
        status.is_ack     = is_ack_reg;
        status.walk_end   = (cnt_reg == win_eff) ||
                            (cur_reg > {2'b0, total_eff});
        status.slot_idle  = slot_rd == SLOT_IDLE;
        status.ack_bad    = ({1'b0, frame_reg} < base_reg) ||
                            ({2'b0, frame_reg} >= win_end) ||
                            (frame_reg > total_eff) ||
                            (slot_rd != SLOT_SENT);
        status.ack_good   = ok_reg;
        status.slide_more = (base_reg <= {1'b0, total_eff}) && (slot_rd == SLOT_ACKED);
        status.out_free   = out_free;
        status.pend_valid = pend_valid_reg;
    end

    // Slot ring and window state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_MAX; i++) begin
                slot_reg[i] <= SLOT_IDLE;
            end
            base_reg       <= BASE_BITS'(1);
            tx_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.walk_hit) begin
                slot_reg[rd_addr] <= SLOT_SENT;
                tx_reg            <= tx_inc;
            end
            if (cmd.ack_set_acked) begin
                slot_reg[rd_addr] <= SLOT_ACKED;
            end
            if (cmd.ack_clear) begin
                slot_reg[rd_addr] <= SLOT_IDLE;
            end
            if (cmd.slide_adv) begin
                slot_reg[rd_addr] <= SLOT_IDLE;
                base_reg          <= base_reg + 1'b1;
            end
            if (cmd.load || cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end else if (cmd.walk_hit) begin
                pend_valid_reg <= 1'b1;
            end
            out_valid_reg <= (out_valid_reg && !out_ready) || cmd.flush || cmd.ack_emit ||
                             (cmd.walk_hit && pend_valid_reg);
        end
    end

    // Item latch, walk position and result staging.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_ack_reg <= in_data.cmd == CMD_ACK;
            frame_reg  <= in_data.ack_frame;
            ok_reg     <= in_data.ack_ok;
            cur_reg    <= {1'b0, base_reg};
            cnt_reg    <= '0;
        end else if (cmd.walk_adv) begin
            cur_reg <= cur_reg + 1'b1;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.set_kind) begin
            kind_reg <= cmd.kind;
        end
        if (cmd.walk_hit) begin
            pend_frame_reg <= cur_reg[15:0];
            pend_tx_reg    <= tx_inc;
        end
        if (cmd.walk_hit && pend_valid_reg) begin
            out_reg.event_kind    <= EV_SENT;
            out_reg.frame_number  <= pend_frame_reg;
            out_reg.window_base   <= base_reg;
            out_reg.all_done      <= done_now;
            out_reg.transmissions <= pend_tx_reg;
            out_reg.last          <= 1'b0;
        end else if (cmd.flush) begin
            out_reg.event_kind    <= pend_valid_reg ? EV_SENT : EV_NONE;
            out_reg.frame_number  <= pend_valid_reg ? pend_frame_reg : 16'd0;
            out_reg.window_base   <= base_reg;
            out_reg.all_done      <= done_now;
            out_reg.transmissions <= pend_valid_reg ? pend_tx_reg : tx_reg;
            out_reg.last          <= 1'b1;
        end else if (cmd.ack_emit) begin
            out_reg.event_kind    <= kind_reg;
            out_reg.frame_number  <= frame_reg;
            out_reg.window_base   <= base_reg;
            out_reg.all_done      <= done_now;
            out_reg.transmissions <= tx_reg;
            out_reg.last          <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/core/srsw_ctrl.sv -----
`timescale 1ns / 1ps

module srsw_ctrl import srsw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DECO  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_ACHK  = 3'd4;
    localparam logic [2:0] ST_SLIDE = 3'd5;
    localparam logic [2:0] ST_AOUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = state_reg == ST_IDLE;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_WALK;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECO;
                end
            end
            ST_DECO: begin
                state_next = status.is_ack ? ST_ACHK : ST_WALK;
            end
            ST_WALK: begin
                cmd.rd_sel = RD_WALK;
                if (status.walk_end) begin
                    state_next = ST_FLUSH;
                end else if (!status.slot_idle) begin
                    cmd.walk_adv = 1'b1;
                end else if (!status.pend_valid || status.out_free) begin
                    cmd.walk_adv = 1'b1;
                    cmd.walk_hit = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ACHK: begin
                cmd.rd_sel   = RD_ACK;
                cmd.set_kind = 1'b1;
                if (status.ack_bad) begin
                    cmd.kind   = EV_IGNORED;
                    state_next = ST_AOUT;
                end else if (status.ack_good) begin
                    cmd.kind          = EV_ACCEPTED;
                    cmd.ack_set_acked = 1'b1;
                    state_next        = ST_SLIDE;
                end else begin
                    cmd.kind      = EV_LOST;
                    cmd.ack_clear = 1'b1;
                    state_next    = ST_AOUT;
                end
            end
            ST_SLIDE: begin
                cmd.rd_sel = RD_BASE;
                if (status.slide_more) begin
                    cmd.slide_adv = 1'b1;
                end else begin
                    state_next = ST_AOUT;
                end
            end
            ST_AOUT: begin
                if (status.out_free) begin
                    cmd.ack_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/selective_repeat_sender_window_core.sv -----
`timescale 1ns / 1ps

// Sender side of a selective repeat ARQ window. Each input transaction is
// either a send pass (cmd 0), which emits one result transaction for every
// frame in the window that has not been sent yet, in ascending order, or an
// acknowledgment outcome (cmd 1) for one frame, which gives exactly one
// result. A send pass gives one "nothing to send" result when no frame goes
// out; the final result of every input transaction carries last. The block
// works on one input transaction at a time. A send pass runs a slot walk
// that visits one ring slot per cycle while the output register can take
// each result, and stops early at the last frame. A good acknowledgment
// slides the window base, and the slide also visits one slot per cycle.
// s_ready returns in the cycle in which the final result is presented, so
// the block takes no new input before it is through with the last one. A
// result waits in an output register, so a stalled result channel only
// holds the block when a further result is due. The window length and frame
// count registers sit at byte addresses 0 and 4 of the APB port and may only
// be written while the block is idle. The slot ring is cleared at reset, so
// no clearing pass is needed.

module selective_repeat_sender_window_core import srsw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    // Result channel.
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WIN_BITS-1:0]   win_len_reg;
    logic [15:0]           frame_count_reg;
    logic [WIN_BITS-1:0]   win_eff;
    logic [FRAME_BITS-1:0] total_eff;
    logic                  cfg_write;
    logic                  cfg_index;
    dp_cmd_t               dp_cmd;
    dp_status_t            dp_status;

    // The register index is the word address; any address maps onto one of
    // the two registers.
    assign pready    = 1'b1;
    assign cfg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_len_reg     <= WIN_BITS'(4);
            frame_count_reg <= 16'd1;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_WIN_LEN:     win_len_reg     <= pwdata[WIN_BITS-1:0];
                REG_FRAME_COUNT: frame_count_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_WIN_LEN:     prdata = {{(32-WIN_BITS){1'b0}}, win_len_reg};
            REG_FRAME_COUNT: prdata = {16'd0, frame_count_reg};
            default:         prdata = '0;
        endcase
    end

    // A window size of zero behaves as one; sizes above the ring depth are
    // clamped to the ring depth.
    always_comb begin
        if (win_len_reg == '0) begin
            win_eff = WIN_BITS'(1);
        end else if (win_len_reg > WIN_BITS'(WIN_LIMIT)) begin
            win_eff = WIN_BITS'(WIN_LIMIT);
        end else begin
            win_eff = win_len_reg;
        end
    end

    // The frame count is taken in its low FRAME_BITS bits.
    assign total_eff = frame_count_reg[FRAME_BITS-1:0];

    // The controller sequences the walk, the acknowledgment check and the
    // base slide; the datapath holds the ring, the counters and the result.
    srsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    srsw_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .win_eff   (win_eff),
        .total_eff (total_eff),
        .in_data   (s_data),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ----- verif/selective_repeat_sender_window_core_tb.sv -----
`timescale 1ns / 1ps

// Testbench for the selective repeat sender window core.
//
// An initial block programs the two registers over APB and fills a queue of
// pending commands. A clocked driver offers these commands on the input
// channel. A clocked monitor takes result transactions from the output
// channel. Each accepted command is run through a window tracker kept in
// this file, which queues the results the block should give. The monitor
// checks each result against the oldest queued expectation.
//
// Random traffic mostly consists of well-formed transmission rounds. A round
// is a send pass, then acknowledgment outcomes for the frames of the window
// in shuffled order, some of them lost. Lost frames are re-sent by a further
// send pass and acknowledged again. Noise commands are mixed in at round
// boundaries, and broken acknowledgments inside rounds.

module selective_repeat_sender_window_core_tb;
    import srsw_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    selective_repeat_sender_window_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // Window tracker: slot ring, base frame, transmission counter and the
    // register copies that the block should hold.
    logic [1:0]  slot_state [WINDOW_MAX];
    int unsigned win_base;
    logic [31:0] tx_count;
    logic [4:0]  cfg_window;
    logic [15:0] cfg_total;

    out_t expected_events [$];
    in_t  pending_cmds [$];

    int err_count     = 0;
    int cycle_count   = 0;
    int queued_count  = 0;
    int offered_cnt   = 0;
    int taken_cnt     = 0;
    int results_taken = 0;
    bit gaps_on       = 1'b1;
    int hold_token    = 0;

    // Oldest frame that the stimulus side believes is not yet acknowledged.
    int unsigned gen_base;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        err_count++;
    endtask

    function automatic void log_event(logic [2:0] kind, int unsigned frame);
        out_t ev;
        ev.event_kind    = kind;
        ev.frame_number  = frame[15:0];
        ev.window_base   = win_base[16:0];
        ev.all_done      = (win_base > cfg_total);
        ev.transmissions = tx_count;
        ev.last          = 1'b0;
        expected_events.push_back(ev);
    endfunction

    // Applies one command to the tracked window and queues its results.
    function automatic void step_window(in_t item);
        int unsigned w;
        int unsigned f;
        int unsigned lim;
        int          n;
        out_t        ev;
        w = {27'd0, cfg_window};
        if (w == 0) w = 1;
        if (w > WIN_LIMIT) w = WIN_LIMIT;
        n = 0;
        if (item.cmd == CMD_SEND) begin
            lim = win_base + w;
            for (f = win_base; f < lim && f <= cfg_total; f++) begin
                if (slot_state[f[SLOT_BITS-1:0]] == SLOT_IDLE) begin
                    slot_state[f[SLOT_BITS-1:0]] = SLOT_SENT;
                    if (tx_count != '1) tx_count++;
                    log_event(EV_SENT, f);
                    n++;
                end
            end
            // A pass that sends nothing still reports once.
            if (n == 0) log_event(EV_NONE, 0);
        end else begin
            f = {16'd0, item.ack_frame};
            if (f < win_base || f >= win_base + w || f > cfg_total ||
                slot_state[f[SLOT_BITS-1:0]] != SLOT_SENT) begin
                log_event(EV_IGNORED, f);
            end else if (item.ack_ok) begin
                slot_state[f[SLOT_BITS-1:0]] = SLOT_ACKED;
                // Slide the base past every acknowledged frame.
                while (win_base <= cfg_total &&
                       slot_state[win_base[SLOT_BITS-1:0]] == SLOT_ACKED) begin
                    slot_state[win_base[SLOT_BITS-1:0]] = SLOT_IDLE;
                    win_base++;
                end
                log_event(EV_ACCEPTED, f);
            end else begin
                slot_state[f[SLOT_BITS-1:0]] = SLOT_IDLE;
                log_event(EV_LOST, f);
            end
        end
        ev = expected_events.pop_back();
        ev.last = 1'b1;
        expected_events.push_back(ev);
    endfunction

    // Input side: record each accepted transaction and predict its results.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            step_window(s_data);
            taken_cnt <= taken_cnt + 1;
        end
    end

    // Driver. A command is accepted once the acceptance count catches up
    // with the offer count; after that a gap is drawn before the next one.
    // The next valid value is worked out first so that s_valid gets a single
    // assignment per falling edge.
    int   send_gap = 0;
    logic next_valid;
    in_t  next_data;

    always @(negedge aclk) begin
        next_valid = s_valid;
        next_data  = s_data;
        if (s_valid && offered_cnt == taken_cnt) begin
            next_valid = 1'b0;
            send_gap   = gaps_on ? $urandom_range(0, 6) : 0;
        end
        if (!next_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_cmds.size() > 0) begin
                next_data  = pending_cmds.pop_front();
                next_valid = 1'b1;
                offered_cnt++;
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    // Receiver. After each accepted result it stalls for a drawn number of
    // cycles. A long hold-off, requested through hold_token, keeps ready low
    // for a stretch so that the block backs up into its input channel.
    int recv_gap     = 0;
    int hold_left    = 0;
    int hold_seen    = 0;
    int results_seen = 0;

    always @(negedge aclk) begin
        if (results_seen != results_taken) begin
            results_seen = results_taken;
            recv_gap     = gaps_on ? $urandom_range(0, 6) : 0;
        end
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: every accepted result is checked field by field.
    out_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken <= results_taken + 1;
            if (expected_events.size() == 0) begin
                report_mismatch("result with nothing expected, frame",
                                m_data.frame_number, 0);
            end else begin
                want = expected_events.pop_front();
                if (m_data.event_kind !== want.event_kind)
                    report_mismatch("event_kind", m_data.event_kind, want.event_kind);
                if (m_data.frame_number !== want.frame_number)
                    report_mismatch("frame_number", m_data.frame_number, want.frame_number);
                if (m_data.window_base !== want.window_base)
                    report_mismatch("window_base", m_data.window_base, want.window_base);
                if (m_data.all_done !== want.all_done)
                    report_mismatch("all_done", m_data.all_done, want.all_done);
                if (m_data.transmissions !== want.transmissions)
                    report_mismatch("transmissions", m_data.transmissions, want.transmissions);
                if (m_data.last !== want.last)
                    report_mismatch("last", m_data.last, want.last);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // One APB write (setup then access cycle) followed by a read-back.
    task automatic reg_write(logic idx, logic [31:0] value);
        logic [31:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_WIN_LEN) cfg_window = value[4:0];
        else cfg_total = value[15:0];
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_WIN_LEN) begin
            if (readback !== {27'd0, value[4:0]})
                report_mismatch("window length read-back", readback, value[4:0]);
        end else begin
            if (readback !== {16'd0, value[15:0]})
                report_mismatch("frame count read-back", readback, value[15:0]);
        end
    endtask

    task automatic program_registers(logic [31:0] win_val, logic [31:0] total_val);
        reg_write(REG_WIN_LEN, win_val);
        reg_write(REG_FRAME_COUNT, total_val);
    endtask

    // Blocks until every queued command is accepted and every expected
    // result has arrived, then lets the block settle.
    task automatic wait_idle();
        while (!(pending_cmds.size() == 0 && offered_cnt == taken_cnt &&
                 expected_events.size() == 0))
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_send();
        in_t item;
        item.cmd       = CMD_SEND;
        item.ack_frame = 16'($urandom_range(0, 65535));
        item.ack_ok    = 1'($urandom_range(0, 1));
        pending_cmds.push_back(item);
        queued_count++;
    endtask

    task automatic queue_ack(int unsigned frame, bit ok);
        in_t item;
        item.cmd       = CMD_ACK;
        item.ack_frame = frame[15:0];
        item.ack_ok    = ok;
        pending_cmds.push_back(item);
        queued_count++;
    endtask

    // One transmission round over the current window: send, acknowledge in
    // shuffled order with some outcomes lost, then resend and re-acknowledge
    // the lost frames until all are through.
    task automatic queue_round(int unsigned w_eff, int unsigned total);
        int unsigned hi;
        int unsigned f;
        int unsigned tmp;
        int          j;
        int          k;
        bit          ok;
        int unsigned order [$];
        int unsigned lost [$];
        int unsigned still_lost [$];
        if (gen_base > total) begin
            // Everything is done; a send pass here reports nothing to send.
            queue_send();
            return;
        end
        hi = gen_base + w_eff - 1;
        if (hi > total) hi = total;
        for (f = gen_base; f <= hi; f++) order.push_back(f);
        for (j = order.size() - 1; j > 0; j--) begin
            k        = $urandom_range(0, j);
            tmp      = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        queue_send();
        foreach (order[j]) begin
            ok = ($urandom_range(0, 3) != 0);
            queue_ack(order[j], ok);
            if (!ok) lost.push_back(order[j]);
            // Broken traffic: a duplicate outcome, or one past the window.
            case ($urandom_range(0, 11))
                0: queue_ack(order[j], 1'b1);
                1: queue_ack(hi + 1, 1'($urandom_range(0, 1)));
                default: ;
            endcase
        end
        while (lost.size() > 0) begin
            // An outcome for a frame that is not in flight yet is ignored.
            if ($urandom_range(0, 4) == 0) queue_ack(lost[0], 1'b1);
            queue_send();
            still_lost.delete();
            foreach (lost[j]) begin
                ok = ($urandom_range(0, 3) != 0);
                queue_ack(lost[j], ok);
                if (!ok) still_lost.push_back(lost[j]);
            end
            lost = still_lost;
        end
        gen_base = hi + 1;
    endtask

    task automatic run_random_phase(logic [31:0] win_val, logic [31:0] total_val,
                                    bit gaps, bit hold, int budget);
        int unsigned w_eff;
        int          stop_at;
        wait_idle();
        program_registers(win_val, total_val);
        gaps_on = gaps;
        if (hold) hold_token++;
        w_eff = {27'd0, win_val[4:0]};
        if (w_eff == 0) w_eff = 1;
        if (w_eff > WIN_LIMIT) w_eff = WIN_LIMIT;
        stop_at = queued_count + budget;
        while (queued_count < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                // Noise between rounds.
                case ($urandom_range(0, 3))
                    0: queue_send();
                    1: queue_ack($urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                    2: queue_ack(gen_base - 1, 1'($urandom_range(0, 1)));
                    default: queue_ack(gen_base + w_eff, 1'($urandom_range(0, 1)));
                endcase
            end else begin
                queue_round(w_eff, {16'd0, total_val[15:0]});
            end
        end
    endtask

    initial begin
        foreach (slot_state[i]) slot_state[i] = SLOT_IDLE;
        win_base   = 1;
        tx_count   = '0;
        cfg_window = 5'd4;
        cfg_total  = 16'd1;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, first with the reset settings: one frame of one.
        queue_send();                 // frame 1 goes out
        queue_send();                 // nothing left to send
        queue_ack(0, 1'b1);           // frame zero lies below the base
        queue_ack(2, 1'b1);           // above the frame count
        queue_ack(1, 1'b0);           // lost outcome
        queue_ack(1, 1'b0);           // no longer in flight
        queue_send();                 // resend of frame 1
        queue_ack(1, 1'b1);           // accepted, base passes the total
        queue_ack(1, 1'b1);           // below the base now
        queue_send();                 // all frames done

        // A zero window acts as one, and zero frames means nothing to send.
        wait_idle();
        program_registers(32'd0, 32'd0);
        queue_send();
        queue_ack(16'hFFFF, 1'b1);

        // Window of two across the full frame range.
        wait_idle();
        program_registers(32'd2, 32'd65535);
        queue_send();                 // frames 2 and 3
        queue_ack(4, 1'b1);           // at base plus window
        queue_ack(3, 1'b1);           // accepted out of order, base stays
        queue_ack(2, 1'b0);           // lost
        queue_send();                 // resend of frame 2 only
        queue_ack(2, 1'b1);           // base slides to 4
        queue_ack(16'hFFFF, 1'b1);    // far beyond the window
        gen_base = 4;

        // Random part. The first phase starts with a long receiver hold-off.
        run_random_phase(32'd16, 32'd300, 1'b1, 1'b1, 60);
        run_random_phase(32'd1, 32'd120, 1'b0, 1'b0, 45);
        run_random_phase(32'hFFFF_FFE3, 32'h5A5A_008C, 1'b1, 1'b0, 35);
        run_random_phase(32'd7, 32'd65535, 1'b1, 1'b0, 50);
        run_random_phase(32'd31, 32'd40, 1'b1, 1'b0, 25);
        run_random_phase(32'd16, 32'hFFFF_FFFF, 1'b0, 1'b0, 40);
        run_random_phase(32'd5, 32'd200, 1'b1, 1'b0, 45);

        wait_idle();
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
